FILE: design/dts_pkg.sv
// Package with shared constants, types and codes for the topological sort block.
`default_nettype none
package dts_pkg;
  localparam int MaxVertices = 4096;
  localparam int MaxEdges    = 65536;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges) + 1;
  localparam int CW = VW + 1;
  localparam logic [EW-1:0] EdgeNone = EW'(MaxEdges);

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAdd   = 2'd1;
  localparam logic [1:0] ModeSort  = 2'd2;
  localparam logic [1:0] ModeRead  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  localparam logic [0:0] RegVertexCount = 1'd0;
endpackage
`default_nettype wire

FILE: design/dts_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
`default_nettype none
module dts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/dfs_topological_sort.sv
// Top level of the depth-first topological sort engine.
//
// The block takes commands on the in_ channel (valid/ready) and returns one
// result transaction per command on the out_ channel. Commands: clear graph,
// add edge, run sort and read next finished vertex. The vertex count is an
// APB register at address 0 (reset 4096).
// A clear empties the head/tail memories, one list entry a cycle. Sort runs
// a pass that clears the visited marks of the V live vertices, tests each
// root, and visits vertices and follows edges, all set by the single
// sequencer that walks one stack step at a time through registered reads.
// After reset the block sweeps the head/tail memories to empty lists before
// it accepts the first command. One command is worked at a time; the result
// sits in an output register, and while the receiver stalls it holds there
// and the block takes no new command. The next command can be taken in the
// cycle after the result transaction.
// Read returns finish order with last_vertex on the final vertex, and
// status 3 once the order is used up.
`default_nettype none
module dfs_topological_sort (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [11:0] in_src_vertex,
  input  wire logic [11:0] in_dst_vertex,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_order_vertex,
  output logic             out_last_vertex,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int VW = dts_pkg::VW;
  localparam int EW = dts_pkg::EW;
  localparam int CW = dts_pkg::CW;
  localparam int AW = EW - 1;

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_ADD0  = 19'h00004,
    S_ADD1  = 19'h00008,
    S_ADD2  = 19'h00010,
    S_RD0   = 19'h00020,
    S_RD1   = 19'h00040,
    S_VCLR  = 19'h00080,
    S_ROOT  = 19'h00100,
    S_RCHK  = 19'h00200,
    S_PUSH0 = 19'h00400,
    S_PUSH1 = 19'h00800,
    S_TOP0  = 19'h01000,
    S_TOP1  = 19'h02000,
    S_EDGE0 = 19'h04000,
    S_EDGE1 = 19'h08000,
    S_EDGE2 = 19'h10000,
    S_POP   = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] vcount_r;
  logic [EW-1:0] used_r, used_nxt;
  logic [CW-1:0] fin_r, fin_nxt, rpos_r, rpos_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] root_r, root_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [VW-1:0] src_r, dst_r, vtx_r, vtx_nxt;
  logic [EW-1:0] ecur_r, ecur_nxt;
  logic [1:0] mode_r;
  logic [1:0] st_r, st_nxt;
  logic [VW-1:0] ov_r, ov_nxt;
  logic lv_r, lv_nxt, ovalid_r, ovalid_nxt;

  // Memory ports.
  logic hd_we, tl_we, tg_we, lk_we, sv_we, se_we, fo_we, vis_we;
  logic [VW-1:0] hd_wa, hd_ra, tl_wa, tl_ra, sv_wa, sv_ra, se_wa, se_ra, fo_wa, fo_ra;
  logic [VW-1:0] vis_wa, vis_ra;
  logic [0:0] vis_wd, vis_rd;
  logic [EW-1:0] hd_wd, hd_rd, tl_wd, tl_rd, lk_wd, lk_rd, se_wd, se_rd;
  logic [AW-1:0] tg_wa, tg_ra, lk_wa, lk_ra;
  logic [VW-1:0] tg_wd, tg_rd, sv_wd, sv_rd, fo_wd, fo_rd;

  dts_ram #(.Width(EW), .Depth(dts_pkg::MaxVertices)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  dts_ram #(.Width(EW), .Depth(dts_pkg::MaxVertices)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  dts_ram #(.Width(VW), .Depth(dts_pkg::MaxEdges)) u_target (
    .clk, .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd));
  dts_ram #(.Width(EW), .Depth(dts_pkg::MaxEdges)) u_link (
    .clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  dts_ram #(.Width(VW), .Depth(dts_pkg::MaxVertices)) u_stkv (
    .clk, .we(sv_we), .waddr(sv_wa), .wdata(sv_wd), .raddr(sv_ra), .rdata(sv_rd));
  dts_ram #(.Width(EW), .Depth(dts_pkg::MaxVertices)) u_stke (
    .clk, .we(se_we), .waddr(se_wa), .wdata(se_wd), .raddr(se_ra), .rdata(se_rd));
  dts_ram #(.Width(VW), .Depth(dts_pkg::MaxVertices)) u_fin (
    .clk, .we(fo_we), .waddr(fo_wa), .wdata(fo_wd), .raddr(fo_ra), .rdata(fo_rd));
  dts_ram #(.Width(1), .Depth(dts_pkg::MaxVertices)) u_visit (
    .clk, .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd));

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == dts_pkg::RegVertexCount) ? 32'(vcount_r) : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CW'(4096);
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == dts_pkg::RegVertexCount) begin
      vcount_r <= cfg_pwdata[CW-1:0];
    end
  end

  // Count in effect.
  logic [CW-1:0] n_eff;
  assign n_eff = (vcount_r < CW'(dts_pkg::MaxVertices)) ? vcount_r
                                                          : CW'(dts_pkg::MaxVertices);

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_status = st_r;
  assign out_order_vertex = ov_r;
  assign out_last_vertex = lv_r;

  logic [VW-1:0] tidx;
  assign tidx = top_r[VW-1:0] - VW'(1);

  // Sequencer: one memory step per cycle while a command is in work.
  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r; fin_nxt = fin_r; rpos_nxt = rpos_r; top_nxt = top_r;
    root_nxt = root_r; clr_nxt = clr_r; vtx_nxt = vtx_r; ecur_nxt = ecur_r;
    st_nxt = st_r; ov_nxt = ov_r; lv_nxt = lv_r;
    ovalid_nxt = ovalid_r && !out_ready;
    hd_we = 1'b0; hd_wa = clr_r[VW-1:0]; hd_wd = dts_pkg::EdgeNone; hd_ra = src_r;
    tl_we = 1'b0; tl_wa = clr_r[VW-1:0]; tl_wd = dts_pkg::EdgeNone; tl_ra = src_r;
    tg_we = 1'b0; tg_wa = used_r[AW-1:0]; tg_wd = dst_r; tg_ra = ecur_r[AW-1:0];
    lk_we = 1'b0; lk_wa = used_r[AW-1:0]; lk_wd = dts_pkg::EdgeNone;
    lk_ra = ecur_r[AW-1:0];
    sv_we = 1'b0; sv_wa = top_r[VW-1:0]; sv_wd = vtx_r; sv_ra = tidx;
    se_we = 1'b0; se_wa = top_r[VW-1:0]; se_wd = hd_rd; se_ra = tidx;
    fo_we = 1'b0; fo_wa = fin_r[VW-1:0]; fo_wd = sv_rd; fo_ra = rpos_r[VW-1:0];
    vis_we = 1'b0; vis_wa = clr_r[VW-1:0]; vis_wd = 1'b0; vis_ra = root_r[VW-1:0];
    case (state_r)
      S_CLR: begin
        hd_we = 1'b1; tl_we = 1'b1;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(dts_pkg::MaxVertices - 1)) begin
          state_nxt = (mode_r == dts_pkg::ModeClear) ? S_OUT : S_IDLE;
          st_nxt = dts_pkg::StOk; ov_nxt = '0; lv_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          st_nxt = dts_pkg::StOk; ov_nxt = '0; lv_nxt = 1'b0;
          case (in_mode)
            dts_pkg::ModeClear: begin
              clr_nxt = '0; used_nxt = '0; fin_nxt = '0; rpos_nxt = '0;
              state_nxt = S_CLR;
            end
            dts_pkg::ModeAdd: state_nxt = S_ADD0;
            dts_pkg::ModeSort: begin
              clr_nxt = '0; fin_nxt = '0; rpos_nxt = '0; root_nxt = '0;
              state_nxt = S_VCLR;
            end
            default: state_nxt = S_RD0;
          endcase
        end
      end
      S_ADD0: begin
        // Range check first, then full check; head/tail read in flight.
        if ({1'b0, src_r} >= n_eff || {1'b0, dst_r} >= n_eff) begin
          st_nxt = dts_pkg::StRange; state_nxt = S_OUT;
        end else if (used_r >= EW'(dts_pkg::MaxEdges)) begin
          st_nxt = dts_pkg::StFull; state_nxt = S_OUT;
        end else begin
          state_nxt = S_ADD1;
        end
      end
      S_ADD1: begin
        tg_we = 1'b1; lk_we = 1'b1;
        tl_we = 1'b1; tl_wa = src_r; tl_wd = used_r;
        if (hd_rd == dts_pkg::EdgeNone) begin
          hd_we = 1'b1; hd_wa = src_r; hd_wd = used_r;
          used_nxt = used_r + EW'(1);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ADD2;
        end
      end
      S_ADD2: begin
        // The old tail still sits on the tail read port; chain it to the new edge.
        lk_we = 1'b1; lk_wa = tl_rd[AW-1:0]; lk_wd = used_r;
        used_nxt = used_r + EW'(1);
        state_nxt = S_OUT;
      end
      S_RD0: begin
        if (rpos_r >= fin_r) begin
          st_nxt = dts_pkg::StEmpty; state_nxt = S_OUT;
        end else state_nxt = S_RD1;
      end
      S_RD1: begin
        ov_nxt = fo_rd;
        rpos_nxt = rpos_r + CW'(1);
        lv_nxt = (rpos_r + CW'(1)) == fin_r;
        state_nxt = S_OUT;
      end
      S_VCLR: begin
        // Clear the visited marks of the live vertices, one a cycle.
        if (clr_r >= n_eff) state_nxt = S_ROOT;
        else begin
          vis_we = 1'b1;
          clr_nxt = clr_r + CW'(1);
        end
      end
      S_ROOT: begin
        hd_ra = root_r[VW-1:0];
        if (root_r >= n_eff) state_nxt = S_OUT;
        else state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (vis_rd[0]) begin
          root_nxt = root_r + CW'(1);
          state_nxt = S_ROOT;
        end else begin
          vtx_nxt = root_r[VW-1:0];
          top_nxt = '0;
          state_nxt = S_PUSH0;
        end
      end
      S_PUSH0: begin
        hd_ra = vtx_r;
        vis_we = 1'b1; vis_wa = vtx_r; vis_wd = 1'b1;
        state_nxt = S_PUSH1;
      end
      S_PUSH1: begin
        sv_we = 1'b1; se_we = 1'b1;
        top_nxt = top_r + CW'(1);
        state_nxt = S_TOP0;
      end
      S_TOP0: state_nxt = S_TOP1;
      S_TOP1: begin
        ecur_nxt = se_rd;
        if (se_rd >= used_r) state_nxt = S_POP;
        else state_nxt = S_EDGE0;
      end
      S_EDGE0: state_nxt = S_EDGE1;
      S_EDGE1: begin
        se_we = 1'b1; se_wa = tidx; se_wd = lk_rd;
        vis_ra = tg_rd;
        state_nxt = S_EDGE2;
      end
      S_EDGE2: begin
        if ({1'b0, tg_rd} < n_eff && !vis_rd[0] &&
            top_r < CW'(dts_pkg::MaxVertices)) begin
          vtx_nxt = tg_rd;
          state_nxt = S_PUSH0;
        end else state_nxt = S_TOP0;
      end
      S_POP: begin
        fo_we = 1'b1;
        fin_nxt = fin_r + CW'(1);
        top_nxt = top_r - CW'(1);
        if (top_r == CW'(1)) begin
          root_nxt = root_r + CW'(1);
          state_nxt = S_ROOT;
        end else state_nxt = S_TOP0;
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; used_r <= '0; fin_r <= '0; rpos_r <= '0;
      ovalid_r <= 1'b0; mode_r <= dts_pkg::ModeSort; top_r <= '0; root_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; used_r <= used_nxt; fin_r <= fin_nxt;
      rpos_r <= rpos_nxt; ovalid_r <= ovalid_nxt; top_r <= top_nxt; root_r <= root_nxt;
      if (in_valid && in_ready) mode_r <= in_mode;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt; ecur_r <= ecur_nxt;
    st_r <= st_nxt; ov_r <= ov_nxt; lv_r <= lv_nxt;
    if (in_valid && in_ready) begin
      src_r <= in_src_vertex; dst_r <= in_dst_vertex;
    end
  end
endmodule
`default_nettype wire

FILE: design/dts_checker.sv
// Port-level checker for the topological sort block, bound to the top level.
`default_nettype none
module dts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [11:0] out_order_vertex,
  input wire logic        out_last_vertex
);
  // No command is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed under stall");
  // Last flag only with a good read.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_vertex |-> out_status == dts_pkg::StOk)
    else $error("last flag with bad status");
  // Non-ok results carry vertex zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dts_pkg::StOk |-> out_order_vertex == 12'd0)
    else $error("vertex on error");
endmodule

bind dfs_topological_sort dts_checker u_dts_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_order_vertex, .out_last_vertex);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the depth-first topological sort engine.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] vertex;
    logic        last;
  } order_result_t;

  typedef struct {
    bit            is_cfg;
    logic [31:0]   cfg_value;
    logic [1:0]    mode;
    logic [11:0]   src;
    logic [11:0]   dst;
    bit            typed;
    order_result_t typed_result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = dts_pkg::ModeClear;
  logic [11:0] in_src_vertex = '0;
  logic [11:0] in_dst_vertex = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [11:0] out_order_vertex;
  logic        out_last_vertex;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dfs_topological_sort DUT (.*);

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the graph, the search and the read pointer.
  logic [12:0] vcount_q;
  logic [dts_pkg::EW-1:0] adj_head [dts_pkg::MaxVertices];
  logic [dts_pkg::EW-1:0] adj_tail [dts_pkg::MaxVertices];
  logic [dts_pkg::VW-1:0] arc_dst [dts_pkg::MaxEdges];
  logic [dts_pkg::EW-1:0] arc_next [dts_pkg::MaxEdges];
  int unsigned arcs_stored;
  bit seen [dts_pkg::MaxVertices];
  logic [dts_pkg::VW-1:0] walk_vertex [dts_pkg::MaxVertices];
  logic [dts_pkg::EW-1:0] walk_arc [dts_pkg::MaxVertices];
  logic [dts_pkg::VW-1:0] post_order [dts_pkg::MaxVertices];
  int unsigned post_len;
  int unsigned read_ptr;

  order_result_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic int unsigned live_vertices();
    return (vcount_q < dts_pkg::MaxVertices) ? 32'(vcount_q) : dts_pkg::MaxVertices;
  endfunction

  function automatic void wipe_graph();
    for (int v = 0; v < dts_pkg::MaxVertices; v++) begin
      adj_head[v] = dts_pkg::EdgeNone;
      adj_tail[v] = dts_pkg::EdgeNone;
    end
    arcs_stored = 0;
    post_len = 0;
    read_ptr = 0;
  endfunction

  // Iterative post-order depth-first search over all live roots.
  function automatic void walk_graph();
    int unsigned n;
    int unsigned top;
    int unsigned e;
    int unsigned t;
    n = live_vertices();
    for (int v = 0; v < dts_pkg::MaxVertices; v++) seen[v] = 1'b0;
    post_len = 0;
    read_ptr = 0;
    for (int unsigned root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        walk_vertex[0] = dts_pkg::VW'(root);
        walk_arc[0] = adj_head[root];
        top = 1;
        while (top > 0) begin
          e = 32'(walk_arc[top-1]);
          if (e >= arcs_stored) begin
            post_order[post_len] = walk_vertex[top-1];
            post_len++;
            top--;
          end else begin
            walk_arc[top-1] = arc_next[e];
            t = 32'(arc_dst[e]);
            if (t < n && !seen[t] && top < dts_pkg::MaxVertices) begin
              seen[t] = 1'b1;
              walk_vertex[top] = dts_pkg::VW'(t);
              walk_arc[top] = adj_head[t];
              top++;
            end
          end
        end
      end
    end
  endfunction

  function automatic order_result_t predict_command(logic [1:0] mode, logic [11:0] src,
                                                    logic [11:0] dst);
    order_result_t r;
    int unsigned n;
    r = '{status: dts_pkg::StOk, vertex: '0, last: 1'b0};
    n = live_vertices();
    case (mode)
      dts_pkg::ModeClear: wipe_graph();
      dts_pkg::ModeAdd: begin
        if (src >= n || dst >= n) begin
          r.status = dts_pkg::StRange;
        end else if (arcs_stored >= dts_pkg::MaxEdges) begin
          r.status = dts_pkg::StFull;
        end else begin
          arc_dst[arcs_stored] = dst;
          arc_next[arcs_stored] = dts_pkg::EdgeNone;
          if (adj_head[src] == dts_pkg::EdgeNone) begin
            adj_head[src] = dts_pkg::EW'(arcs_stored);
          end else begin
            arc_next[adj_tail[src]] = dts_pkg::EW'(arcs_stored);
          end
          adj_tail[src] = dts_pkg::EW'(arcs_stored);
          arcs_stored++;
        end
      end
      dts_pkg::ModeSort: walk_graph();
      default: begin
        if (read_ptr >= post_len) begin
          r.status = dts_pkg::StEmpty;
        end else begin
          r.vertex = post_order[read_ptr];
          read_ptr++;
          r.last = (read_ptr == post_len);
        end
      end
    endcase
    return r;
  endfunction

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker: each transaction against the oldest expectation.
  always @(posedge clk) begin
    order_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d vertex=%0d last=%0d", $time,
                 out_status, out_order_vertex, out_last_vertex);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_order_vertex !== want.vertex) begin
          errors++;
          $display("%0t: order_vertex expected %0d actual %0d", $time, want.vertex,
                   out_order_vertex);
        end
        if (out_last_vertex !== want.last) begin
          errors++;
          $display("%0t: last_vertex expected %0d actual %0d", $time, want.last,
                   out_last_vertex);
        end
      end
    end
  end

  // Send one command transaction; hold valid high across back-to-back commands.
  task automatic issue(logic [1:0] mode, logic [11:0] src, logic [11:0] dst, bit typed = 0,
                       order_result_t typed_result = '0);
    order_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_src_vertex <= src;
    in_dst_vertex <= dst;
    do @(posedge clk); while (!in_ready);
    r = predict_command(mode, src, dst);
    pending_results.insert(pending_results.size(), typed ? typed_result : r);
  endtask

  // Register write while the block is idle.
  task automatic write_vertex_count(logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= dts_pkg::RegVertexCount;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    vcount_q = value[12:0];
  endtask

  // One random graph: optional reconfigure and clear, edges, an optional read, sort, then reads.
  task automatic random_graph(ref int sent);
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [11:0] s;
    logic [11:0] d;
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(39);
      if (pick == 0) write_vertex_count(0);
      else if (pick == 1) write_vertex_count(dts_pkg::MaxVertices);
      else if (pick == 2) write_vertex_count(13'h1FFF);
      else write_vertex_count($urandom_range(40, 1));
    end
    if ($urandom_range(7) == 0) begin
      issue(dts_pkg::ModeClear, 12'($urandom), 12'($urandom));
      sent++;
    end
    n = live_vertices();
    k = $urandom_range(20);
    for (int i = 0; i < k; i++) begin
      if (n == 0 || $urandom_range(7) == 0) begin
        s = 12'($urandom);
        d = 12'($urandom);
      end else begin
        s = 12'($urandom_range(n - 1));
        d = 12'($urandom_range(n - 1));
      end
      issue(dts_pkg::ModeAdd, s, d);
      sent++;
    end
    if ($urandom_range(9) == 0) begin
      issue(dts_pkg::ModeRead, 12'($urandom), 12'($urandom));
      sent++;
    end
    issue(dts_pkg::ModeSort, 12'($urandom), 12'($urandom));
    sent++;
    k = ((post_len < 40) ? post_len : 40) + $urandom_range(2);
    for (int i = 0; i < k; i++) begin
      issue(dts_pkg::ModeRead, 12'($urandom), 12'($urandom));
      sent++;
    end
  endtask

  stim_row_t plan[$];

  function automatic stim_row_t cmd(logic [1:0] mode, logic [11:0] src, logic [11:0] dst,
                                    bit typed = 0, logic [1:0] st = dts_pkg::StOk,
                                    logic [11:0] v = '0, logic last = 1'b0);
    stim_row_t row;
    row.is_cfg = 0;
    row.cfg_value = '0;
    row.mode = mode;
    row.src = src;
    row.dst = dst;
    row.typed = typed;
    row.typed_result = '{status: st, vertex: v, last: last};
    return row;
  endfunction

  function automatic stim_row_t cfg(logic [31:0] value);
    stim_row_t row;
    row = cmd(dts_pkg::ModeClear, '0, '0);
    row.is_cfg = 1;
    row.cfg_value = value;
    return row;
  endfunction

  // Main sequence.
  initial begin
    int sent;
    int phase_idle[4];
    int phase_stall[4];
    vcount_q = 13'(dts_pkg::MaxVertices);
    wipe_graph();
    phase_idle = '{0, 66, 0, 29};
    phase_stall = '{0, 0, 66, 29};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, every command and the range, empty-read and vertex-count corner cases.
    plan = '{
      cmd(dts_pkg::ModeRead, 12'hFFF, 12'hFFF, 1, dts_pkg::StEmpty),
      cmd(dts_pkg::ModeAdd, 12'hFFF, 12'h000, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeAdd, 12'h000, 12'hFFF, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeAdd, 12'hAAA, 12'h555, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeSort, 12'h000, 12'h000, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeRead, 12'h000, 12'h000),
      cmd(dts_pkg::ModeRead, 12'h000, 12'h000),
      cfg(3),
      cmd(dts_pkg::ModeClear, 12'h000, 12'h000, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeAdd, 12'd0, 12'd1),
      cmd(dts_pkg::ModeAdd, 12'd1, 12'd2),
      cmd(dts_pkg::ModeAdd, 12'd0, 12'd2),
      cmd(dts_pkg::ModeAdd, 12'd2, 12'd0),
      cmd(dts_pkg::ModeAdd, 12'd3, 12'd0, 1, dts_pkg::StRange),
      cmd(dts_pkg::ModeAdd, 12'd0, 12'd3, 1, dts_pkg::StRange),
      cmd(dts_pkg::ModeSort, 12'd0, 12'd0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0, 1, dts_pkg::StOk, 12'd2, 1'b0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0, 1, dts_pkg::StOk, 12'd1, 1'b0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0, 1, dts_pkg::StOk, 12'd0, 1'b1),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0, 1, dts_pkg::StEmpty),
      cfg(0),
      cmd(dts_pkg::ModeAdd, 12'd0, 12'd0, 1, dts_pkg::StRange),
      cmd(dts_pkg::ModeSort, 12'd0, 12'd0, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0, 1, dts_pkg::StEmpty),
      cfg(32'h1FFF),
      cmd(dts_pkg::ModeAdd, 12'hFFF, 12'hFFF, 1, dts_pkg::StOk),
      cmd(dts_pkg::ModeAdd, 12'd4, 12'd2),
      cfg(3),
      cmd(dts_pkg::ModeSort, 12'd0, 12'd0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0),
      cmd(dts_pkg::ModeRead, 12'd0, 12'd0)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_vertex_count(plan[i].cfg_value);
      else issue(plan[i].mode, plan[i].src, plan[i].dst, plan[i].typed,
                 plan[i].typed_result);
    end

    // Random graphs under each idling mix.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      sent = 0;
      while (sent < 360) random_graph(sent);
    end

    // A fuller graph at a fixed count, with a range check at its edge.
    idle_pct = 0;
    stall_pct = 0;
    write_vertex_count(64);
    issue(dts_pkg::ModeClear, 12'd0, 12'd0);
    for (int i = 0; i < 8; i++) begin
      issue(dts_pkg::ModeAdd, 12'($urandom_range(63)), 12'($urandom_range(63)));
    end
    issue(dts_pkg::ModeAdd, 12'd64, 12'd0, 1,
          '{status: dts_pkg::StRange, vertex: 12'd0, last: 1'b0});
    issue(dts_pkg::ModeSort, 12'd0, 12'd0);
    for (int i = 0; i < 66; i++) issue(dts_pkg::ModeRead, 12'd0, 12'd0);

    // Drain and report.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2s;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
